[rtl/lspd_pkg.sv]
package lspd_pkg;

    localparam int ANGLE_BINS   = 360;
    localparam int FULL_TURN_Q6 = ANGLE_BINS * 64;

    typedef enum logic [3:0] {
        P_SYNC0, P_SYNC1, P_TYPE, P_COUNT, P_START0, P_START1,
        P_END0, P_END1, P_CSUM0, P_CSUM1, P_SAMPLE
    } t_parse;

    typedef enum logic [2:0] {
        B_IDLE, B_DIV, B_CORR, B_WRAP, B_LOOK, B_DECIDE, B_OUT
    } t_back;

    // sample job handed from parser to compute side
    typedef struct packed {
        logic        clear_marks;
        logic [7:0]  total;
        logic [14:0] start_q6;
        logic [14:0] span_q6;
        logic [13:0] distance;
        logic [9:0]  intensity;
        logic [7:0]  index;
    } t_job;

    // CORDIC arctangent steps in 2^-16 degree
    function automatic logic [21:0] arc_q16(input logic [4:0] i);
        logic [21:0] v;
        unique case (i)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/lspd_front.sv]
module lspd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [15:0]         i_header,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    output logic                o_ready,
    output logic                o_job_valid,
    output lspd_pkg::t_job      o_job,
    input  logic                i_job_ready
);
    lspd_pkg::t_parse r_pos, n_pos;
    logic [7:0]  r_total, r_cnt, r_b0, r_b1, r_lo;
    logic [15:0] r_start, r_end;
    logic [1:0]  r_phase;
    logic        r_clr;
    logic        w_take;
    logic [14:0] w_s, w_e;
    logic [15:0] w_sa, w_ea;

    // a completed sample needs a free queue slot before the byte is taken
    assign o_ready = !(r_pos == lspd_pkg::P_SAMPLE && r_phase == 2'd2) || i_job_ready;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        w_sa = {1'b0, r_start[15:1]};
        w_ea = {1'b0, r_end[15:1]};
        w_s  = 15'(w_sa >= 16'(lspd_pkg::FULL_TURN_Q6) ? w_sa - 16'(lspd_pkg::FULL_TURN_Q6) : w_sa);
        w_e  = 15'(w_ea >= 16'(lspd_pkg::FULL_TURN_Q6) ? w_ea - 16'(lspd_pkg::FULL_TURN_Q6) : w_ea);
        o_job.clear_marks = r_clr;
        o_job.total       = r_total;
        o_job.start_q6    = w_s;
        o_job.span_q6     = (w_e >= w_s) ? w_e - w_s : 15'(lspd_pkg::FULL_TURN_Q6) - w_s + w_e;
        o_job.distance    = {i_byte, r_b1[7:2]};
        o_job.intensity   = {r_b1[1:0], r_b0};
        o_job.index       = r_cnt;
        o_job_valid = i_valid && r_pos == lspd_pkg::P_SAMPLE && r_phase == 2'd2;
    end

    always_comb begin
        n_pos = r_pos;
        unique case (r_pos)
            lspd_pkg::P_SYNC0:  if (i_byte == i_header[7:0]) n_pos = lspd_pkg::P_SYNC1;
            lspd_pkg::P_SYNC1:  n_pos = (i_byte == i_header[15:8]) ? lspd_pkg::P_TYPE
                                                                  : lspd_pkg::P_SYNC0;
            lspd_pkg::P_TYPE:   n_pos = lspd_pkg::P_COUNT;
            lspd_pkg::P_COUNT:  n_pos = lspd_pkg::P_START0;
            lspd_pkg::P_START0: n_pos = lspd_pkg::P_START1;
            lspd_pkg::P_START1: n_pos = lspd_pkg::P_END0;
            lspd_pkg::P_END0:   n_pos = lspd_pkg::P_END1;
            lspd_pkg::P_END1:   n_pos = lspd_pkg::P_CSUM0;
            lspd_pkg::P_CSUM0:  n_pos = lspd_pkg::P_CSUM1;
            lspd_pkg::P_CSUM1:  n_pos = (r_total != 8'd0) ? lspd_pkg::P_SAMPLE
                                                          : lspd_pkg::P_SYNC0;
            lspd_pkg::P_SAMPLE: if (r_phase == 2'd2 && (r_cnt + 8'd1 >= r_total ||
                                    r_cnt == 8'hFF)) n_pos = lspd_pkg::P_SYNC0;
            default:            n_pos = lspd_pkg::P_SYNC0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= lspd_pkg::P_SYNC0;
            r_total <= '0; r_cnt <= '0; r_phase <= '0; r_clr <= 1'b0;
            r_start <= '0; r_end <= '0;
        end else if (w_take) begin
            r_pos <= n_pos;
            case (r_pos)
                lspd_pkg::P_SYNC1:  if (i_byte == i_header[15:8]) r_clr <= 1'b1;
                lspd_pkg::P_COUNT:  r_total <= i_byte;
                lspd_pkg::P_START0: r_lo <= i_byte;
                lspd_pkg::P_START1: r_start <= {i_byte, r_lo};
                lspd_pkg::P_END0:   r_lo <= i_byte;
                lspd_pkg::P_END1:   r_end <= {i_byte, r_lo};
                lspd_pkg::P_CSUM1: begin
                    r_cnt <= '0; r_phase <= '0;
                end
                lspd_pkg::P_SAMPLE: begin
                    if (r_phase == 2'd0) begin
                        r_b0 <= i_byte; r_phase <= 2'd1;
                    end else if (r_phase == 2'd1) begin
                        r_b1 <= i_byte; r_phase <= 2'd2;
                    end else begin
                        r_phase <= 2'd0; r_cnt <= r_cnt + 8'd1; r_clr <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

[rtl/lspd_queue.sv]
module lspd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  lspd_pkg::t_job i_job,
    output logic           o_ready,
    output logic           o_valid,
    output lspd_pkg::t_job o_job,
    input  logic           i_ready
);
    lspd_pkg::t_job r_q [2];
    logic [1:0] r_cnt;
    logic       r_wp, r_rp;
    logic       w_push, w_pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_cnt <= '0; r_wp <= 1'b0; r_rp <= 1'b0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

[rtl/lspd_back.sv]
module lspd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  lspd_pkg::t_job i_job,
    output logic           o_ready,
    output logic           o_valid,
    output logic [55:0]    o_data,
    output logic           o_keep,
    output logic           o_last,
    input  logic           i_ready
);
    localparam logic signed [17:0] TURN = 18'(lspd_pkg::FULL_TURN_Q6);

    lspd_pkg::t_back r_st, n_st;
    lspd_pkg::t_job  r_job;
    logic [22:0] r_rem;      // dividend, shifted out MSB first
    logic [7:0]  r_part;     // partial remainder
    logic [22:0] r_quo;
    logic [4:0]  r_it;
    logic signed [51:0] r_cx, r_cy;   // vector, magnitudes scaled by 2^20
    logic signed [24:0] r_cz;         // angle, 2^-16 degree
    logic        r_neg;
    logic signed [17:0] r_ang;
    logic [8:0]  r_bin;
    logic [13:0] r_min;
    logic        r_occ, r_keep;
    logic [lspd_pkg::ANGLE_BINS-1:0] r_marks;
    logic [13:0] r_mem [lspd_pkg::ANGLE_BINS];
    logic [8:0]  w_trial;
    logic [7:0]  w_den;
    logic [17:0] w_ten;
    logic [17:0] w_diff;
    logic        w_neg;
    logic [27:0] w_cden;
    logic [25:0] w_cnum;
    logic signed [51:0] w_dx, w_dy, w_ny;
    logic [21:0] w_arc;
    logic [23:0] w_zc;
    logic [23:0] w_zr;
    logic signed [13:0] w_corr;
    logic [14:0] w_quo;
    logic        w_keep;
    logic [lspd_pkg::ANGLE_BINS-1:0] w_hot;

    assign w_den   = r_job.total - 8'd1;
    assign w_trial = {r_part, r_rem[22]};
    assign o_ready = r_st == lspd_pkg::B_IDLE;
    assign o_valid = r_st == lspd_pkg::B_OUT;

    // correction operands: 15530*d and |218*(1553 - 10*d)|
    always_comb begin
        w_ten  = 18'(i_job.distance) * 18'd10;
        w_neg  = w_ten > 18'd1553;
        w_diff = w_neg ? w_ten - 18'd1553 : 18'd1553 - w_ten;
        w_cden = 28'(i_job.distance) * 28'd15530;
        w_cnum = 26'(w_diff) * 26'd218;
    end

    // negative y is shifted as minus the shifted magnitude
    assign w_ny  = -r_cy;
    assign w_dx  = r_cx >>> r_it;
    assign w_dy  = r_cy[51] ? -(w_ny >>> r_it) : (r_cy >>> r_it);
    assign w_arc = lspd_pkg::arc_q16(r_it);

    // clamp at zero, round to 1/64 degree
    assign w_zc   = r_cz[24] ? 24'd0 : r_cz[23:0];
    assign w_zr   = w_zc + 24'd512;
    assign w_corr = (r_job.distance == 14'd0) ? 14'sd0
                  : r_neg ? -$signed({1'b0, w_zr[22:10]}) : $signed({1'b0, w_zr[22:10]});
    assign w_quo  = (r_job.total > 8'd1) ? r_quo[14:0] : 15'd0;
    assign w_keep = !r_occ || r_job.distance < r_min;
    assign w_hot  = {{(lspd_pkg::ANGLE_BINS-1){1'b0}}, 1'b1} << r_bin;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            lspd_pkg::B_IDLE:   if (i_valid) n_st = lspd_pkg::B_DIV;
            lspd_pkg::B_DIV:    if (r_it == 5'd22) n_st = lspd_pkg::B_CORR;
            lspd_pkg::B_CORR:   n_st = lspd_pkg::B_WRAP;
            lspd_pkg::B_WRAP:   if (r_ang > 18'sd0 && r_ang <= TURN) n_st = lspd_pkg::B_LOOK;
            lspd_pkg::B_LOOK:   n_st = lspd_pkg::B_DECIDE;
            lspd_pkg::B_DECIDE: n_st = lspd_pkg::B_OUT;
            lspd_pkg::B_OUT:    if (i_ready) n_st = lspd_pkg::B_IDLE;
            default:            n_st = lspd_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            lspd_pkg::B_IDLE: begin
                r_job <= i_job;
                r_rem <= 23'(i_job.index) * 23'(i_job.span_q6);
                r_part <= '0; r_quo <= '0; r_it <= '0;
                r_cx <= $signed({4'd0, w_cden, 20'd0});
                r_cy <= $signed({6'd0, w_cnum, 20'd0});
                r_cz <= '0;
                r_neg <= w_neg;
            end
            lspd_pkg::B_DIV: begin
                // restoring divide, one quotient bit per cycle
                if (w_trial >= {1'b0, w_den}) begin
                    r_part <= 8'(w_trial - {1'b0, w_den});
                    r_quo  <= {r_quo[21:0], 1'b1};
                end else begin
                    r_part <= w_trial[7:0];
                    r_quo  <= {r_quo[21:0], 1'b0};
                end
                r_rem <= {r_rem[21:0], 1'b0};
                // CORDIC vectoring step on the same count
                if (!r_cy[51]) begin
                    r_cx <= r_cx + w_dy;
                    r_cy <= r_cy - w_dx;
                    r_cz <= r_cz + $signed({3'd0, w_arc});
                end else begin
                    r_cx <= r_cx - w_dy;
                    r_cy <= r_cy + w_dx;
                    r_cz <= r_cz - $signed({3'd0, w_arc});
                end
                r_it  <= r_it + 5'd1;
            end
            lspd_pkg::B_CORR: r_ang <= {3'b0, r_job.start_q6} + {3'b0, w_quo}
                + {{4{w_corr[13]}}, w_corr};
            lspd_pkg::B_WRAP: begin
                if (r_ang <= 18'sd0) r_ang <= r_ang + TURN;
                else if (r_ang > TURN) r_ang <= r_ang - TURN;
                else r_bin <= (r_ang[17:6] >= 12'(lspd_pkg::ANGLE_BINS)) ? 9'd0 : r_ang[14:6];
            end
            lspd_pkg::B_LOOK: begin
                r_min <= r_mem[r_bin];
                r_occ <= r_marks[r_bin] && !r_job.clear_marks;
            end
            lspd_pkg::B_DECIDE: begin
                r_keep <= w_keep;
                if (w_keep) r_mem[r_bin] <= r_job.distance;
            end
            default: ;
        endcase
        if (!i_rst_n) begin
            r_st <= lspd_pkg::B_IDLE;
            r_marks <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == lspd_pkg::B_DECIDE) begin
                // a cleared packet always keeps its first sample
                if (r_job.clear_marks) r_marks <= w_hot;
                else if (w_keep) r_marks <= r_marks | w_hot;
            end
        end
    end

    assign o_data = {r_job.index, r_job.intensity, r_job.distance, r_ang[14:0], r_bin};
    assign o_keep = r_keep;
    assign o_last = r_job.index + 8'd1 == r_job.total;
endmodule

[rtl/lidar_scan_packet_decoder_core.sv]
// Decodes sensor scan packets one byte per transfer. A parser front end
// takes a byte every cycle except when a finished sample finds the two-entry
// job queue full; the back end takes one sample at a time and holds on output
// stalls: it accepts, runs the interpolation divider and the correction CORDIC
// side by side for 23 steps, adds, wraps and bins, looks the bin up, decides
// and then presents the result on the output. Results:
// tdata = bin_index[8:0], angle_q6[23:9], distance[37:24], intensity[47:38],
// sample_index[55:48]; tuser = keep; tlast = last_of_packet.
// Per-bin minima sit in a 360-entry memory; occupancy flags clear on each sync.
module lidar_scan_packet_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // bin_index, angle_q6, distance, intensity, sample_index
    output logic        m_axis_tuser,   // keep
    output logic        m_axis_tlast
);
    logic [15:0] r_header;
    logic        w_fv, w_fr, w_qv, w_qr;
    lspd_pkg::t_job w_fj, w_qj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_header <= 16'h55AA;
        else if (i_cfg_we) r_header <= i_cfg_wdata;
    end

    lspd_front u_front (.i_clk, .i_rst_n, .i_header(r_header), .i_valid(s_axis_tvalid),
        .i_byte(s_axis_tdata), .o_ready(s_axis_tready), .o_job_valid(w_fv),
        .o_job(w_fj), .i_job_ready(w_fr));

    lspd_queue u_queue (.i_clk, .i_rst_n, .i_valid(w_fv), .i_job(w_fj),
        .o_ready(w_fr), .o_valid(w_qv), .o_job(w_qj), .i_ready(w_qr));

    lspd_back u_back (.i_clk, .i_rst_n, .i_valid(w_qv),
        .i_job(w_qj), .o_ready(w_qr), .o_valid(m_axis_tvalid), .o_data(m_axis_tdata),
        .o_keep(m_axis_tuser), .o_last(m_axis_tlast), .i_ready(m_axis_tready));
endmodule
